>>> sv/psd_pkg.sv
package psd_pkg;

  localparam int OUT_W = 43;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  typedef enum logic [1:0] {
    RGN_DEGEN  = 2'd0,
    RGN_BEFORE = 2'd1,
    RGN_PAST   = 2'd2,
    RGN_INNER  = 2'd3
  } region_e;

endpackage

>>> sv/psd_in_if.sv
interface psd_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
                  input ready);
  modport sink (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
                output ready);
endinterface

>>> sv/psd_out_if.sv
interface psd_out_if;
  logic        valid;
  logic        ready;
  logic [42:0] distance_sq;
  logic [1:0]  nearest_region;

  modport source (output valid, distance_sq, nearest_region, input ready);
  modport sink (input valid, distance_sq, nearest_region, output ready);
endinterface

>>> sv/psd_front.sv
module psd_front import psd_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8,
  localparam int DW = 2 * COORD_BITS + 1,
  localparam int QW = DW + FRAC_BITS,
  localparam int NW = 2 * DW + FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  output logic                         valid_o,
  output logic [NW-1:0]                num_o,
  output logic [DW-1:0]                len_o,
  output logic [QW-1:0]                direct_o,
  output region_e                      region_o
);

  localparam int C  = COORD_BITS;
  localparam int DF = C + 1;
  localparam int PW = 2 * DF;
  localparam int H  = C + 1;
  localparam int HW = DW - H;
  localparam int SW = 2 * DW;

  logic [5:0] vld_q;

  logic signed [DF-1:0] abx_q, aby_q, apx_q, apy_q, bpx_q, bpy_q;
  logic signed [PW-1:0] abx2_q, aby2_q, apx2_q, apy2_q, bpx2_q, bpy2_q;
  logic signed [PW-1:0] pdx_q, pdy_q, pc1_q, pc2_q;
  logic [DW-1:0]        len3_q, ap2_q, bp2_q;
  logic signed [PW-1:0] dot_q, cross_q;
  logic [DW-1:0]        len4_q, len5_q, len6_q, xabs_q;
  logic [QW-1:0]        dir4_q, dir5_q, dir6_q;
  region_e              rg4_q, rg5_q, rg6_q;
  region_e              rg_d;
  logic [2*HW-1:0]      hh_q;
  logic [HW+H-1:0]      hl_q;
  logic [2*H-1:0]       ll_q;
  logic [SW-1:0]        sq_d;
  logic [NW-1:0]        num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_comb begin
    if (len3_q == '0) begin
      rg_d = RGN_DEGEN;
    end else if (dot_q[PW-1]) begin
      rg_d = RGN_BEFORE;
    end else if ($unsigned(dot_q) > {1'b0, len3_q}) begin
      rg_d = RGN_PAST;
    end else begin
      rg_d = RGN_INNER;
    end
  end

  assign sq_d = (SW'(hh_q) << (2 * H)) + (SW'(hl_q) << (H + 1)) + SW'(ll_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // differences
      abx_q <= {bx_i[C-1], bx_i} - {ax_i[C-1], ax_i};
      aby_q <= {by_i[C-1], by_i} - {ay_i[C-1], ay_i};
      apx_q <= {px_i[C-1], px_i} - {ax_i[C-1], ax_i};
      apy_q <= {py_i[C-1], py_i} - {ay_i[C-1], ay_i};
      bpx_q <= {px_i[C-1], px_i} - {bx_i[C-1], bx_i};
      bpy_q <= {py_i[C-1], py_i} - {by_i[C-1], by_i};
      // products
      abx2_q <= abx_q * abx_q;
      aby2_q <= aby_q * aby_q;
      apx2_q <= apx_q * apx_q;
      apy2_q <= apy_q * apy_q;
      bpx2_q <= bpx_q * bpx_q;
      bpy2_q <= bpy_q * bpy_q;
      pdx_q  <= apx_q * abx_q;
      pdy_q  <= apy_q * aby_q;
      pc1_q  <= abx_q * apy_q;
      pc2_q  <= aby_q * apx_q;
      // sums
      len3_q  <= {1'b0, abx2_q[DW-2:0]} + {1'b0, aby2_q[DW-2:0]};
      ap2_q   <= {1'b0, apx2_q[DW-2:0]} + {1'b0, apy2_q[DW-2:0]};
      bp2_q   <= {1'b0, bpx2_q[DW-2:0]} + {1'b0, bpy2_q[DW-2:0]};
      dot_q   <= pdx_q + pdy_q;
      cross_q <= pc1_q - pc2_q;
      // classify
      rg4_q  <= rg_d;
      len4_q <= len3_q;
      xabs_q <= cross_q[PW-1] ? DW'(-cross_q) : DW'(cross_q);
      dir4_q <= (rg_d == RGN_PAST) ? (QW'(bp2_q) << FRAC_BITS) : (QW'(ap2_q) << FRAC_BITS);
      // split square of cross
      hh_q   <= xabs_q[DW-1:H] * xabs_q[DW-1:H];
      hl_q   <= xabs_q[DW-1:H] * xabs_q[H-1:0];
      ll_q   <= xabs_q[H-1:0] * xabs_q[H-1:0];
      rg5_q  <= rg4_q;
      len5_q <= len4_q;
      dir5_q <= dir4_q;
      // numerator
      num_q  <= NW'(sq_d) << FRAC_BITS;
      rg6_q  <= rg5_q;
      len6_q <= len5_q;
      dir6_q <= dir5_q;
    end
  end

  assign valid_o  = vld_q[5];
  assign num_o    = num_q;
  assign len_o    = len6_q;
  assign direct_o = dir6_q;
  assign region_o = rg6_q;

endmodule

>>> sv/psd_div.sv
module psd_div import psd_pkg::*; #(
  parameter int DW = 33,
  parameter int QW = 41,
  parameter int NW = 74
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NW-1:0]    num_i,
  input  logic [DW-1:0]    len_i,
  input  logic [QW-1:0]    direct_i,
  input  region_e          region_i,
  output logic             valid_o,
  output logic [OUT_W-1:0] dist_o,
  output region_e          region_o
);

  localparam int VW = (QW > OUT_W) ? QW : OUT_W;

  logic          vld [QW+1];
  logic [DW-1:0] rem [QW+1];
  logic [QW-1:0] quo [QW+1];
  logic [QW-1:0] low [QW+1];
  logic [DW-1:0] len [QW+1];
  logic [QW-1:0] dir [QW+1];
  region_e       rg  [QW+1];

  assign vld[0] = valid_i;
  assign rem[0] = num_i[NW-1:QW];
  assign quo[0] = '0;
  assign low[0] = num_i[QW-1:0];
  assign len[0] = len_i;
  assign dir[0] = direct_i;
  assign rg[0]  = region_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem[k], low[k][QW-1-k]};
    assign diff  = trial - {1'b0, len[k]};
    assign ge    = trial >= {1'b0, len[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo[k+1] <= quo[k] | (QW'(ge) << (QW - 1 - k));
        low[k+1] <= low[k];
        len[k+1] <= len[k];
        dir[k+1] <= dir[k];
        rg[k+1]  <= rg[k];
      end
    end
  end

  logic [VW-1:0]    res_ext;
  logic             out_vld_q;
  logic [OUT_W-1:0] dist_q;
  region_e          rg_q;

  assign res_ext = (rg[QW] == RGN_INNER) ? VW'(quo[QW]) : VW'(dir[QW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q <= (res_ext > VW'(OUT_MAX)) ? OUT_MAX : OUT_W'(res_ext);
      rg_q   <= rg[QW];
    end
  end

  assign valid_o  = out_vld_q;
  assign dist_o   = dist_q;
  assign region_o = rg_q;

endmodule

>>> sv/point_segment_distance_sq_2d.sv
// throughput: one beat per cycle while the output is not stalled; six arithmetic stages feed a restoring divider
// with one quotient bit per stage, then an output register
// a stalled output holds the whole pipeline; nothing is dropped or repeated
// reset: rst_ni asynchronous active low, clears all valid bits
module point_segment_distance_sq_2d import psd_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psd_in_if.sink    pt_i,
  psd_out_if.source res_o
);

  localparam int DW = 2 * COORD_BITS + 1;
  localparam int QW = DW + FRAC_BITS;
  localparam int NW = 2 * DW + FRAC_BITS;

  logic          en;
  logic          fr_vld;
  logic [NW-1:0] fr_num;
  logic [DW-1:0] fr_len;
  logic [QW-1:0] fr_dir;
  region_e       fr_rg;
  logic          out_vld;
  region_e       out_rg;

  assign en         = !out_vld || res_o.ready;
  assign pt_i.ready = en;

  psd_front #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pt_i.valid),
    .px_i    (pt_i.point_x),
    .py_i    (pt_i.point_y),
    .ax_i    (pt_i.start_x),
    .ay_i    (pt_i.start_y),
    .bx_i    (pt_i.end_x),
    .by_i    (pt_i.end_y),
    .valid_o (fr_vld),
    .num_o   (fr_num),
    .len_o   (fr_len),
    .direct_o(fr_dir),
    .region_o(fr_rg)
  );

  psd_div #(
    .DW(DW),
    .QW(QW),
    .NW(NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .num_i   (fr_num),
    .len_i   (fr_len),
    .direct_i(fr_dir),
    .region_i(fr_rg),
    .valid_o (out_vld),
    .dist_o  (res_o.distance_sq),
    .region_o(out_rg)
  );

  assign res_o.valid          = out_vld;
  assign res_o.nearest_region = out_rg;

endmodule

>>> sv/psd_checker.sv
module psd_checker import psd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [OUT_W-1:0] dist_i,
  input logic [1:0]       region_i
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(dist_i) && $stable(region_i))
    else $error("result beat changed while stalled");

  // input side only stalls behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // endpoint regions have a strictly positive distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (region_i == RGN_BEFORE || region_i == RGN_PAST) |-> dist_i != '0)
    else $error("zero distance outside the segment");

  // nothing valid right out of reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind point_segment_distance_sq_2d psd_checker u_psd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (pt_i.ready),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .dist_i     (res_o.distance_sq),
  .region_i   (res_o.nearest_region)
);

>>> sim/tb_pkg.sv
package tb_pkg;
  import psd_pkg::*;

  typedef struct {
    logic [OUT_W-1:0] dist_sq;
    region_e          region;
  } psd_result_t;

  class distance_board;
    psd_result_t pending[$];
    int          mismatches;

    // squared distance from p to segment ab, 8 fraction bits, truncated
    function automatic psd_result_t predict(logic signed [15:0] px, logic signed [15:0] py,
                                            logic signed [15:0] ax, logic signed [15:0] ay,
                                            logic signed [15:0] bx, logic signed [15:0] by);
      psd_result_t r;
      longint abx, aby, apx, apy, len, dot, cr, d;
      logic [127:0] num, q;
      abx = longint'(bx) - longint'(ax);
      aby = longint'(by) - longint'(ay);
      apx = longint'(px) - longint'(ax);
      apy = longint'(py) - longint'(ay);
      len = abx * abx + aby * aby;
      dot = apx * abx + apy * aby;
      if (len == 0) begin
        r.region = RGN_DEGEN;
        d = apx * apx + apy * apy;
        q = 128'(d) << 8;
      end else if (dot < 0) begin
        r.region = RGN_BEFORE;
        d = apx * apx + apy * apy;
        q = 128'(d) << 8;
      end else if (dot > len) begin
        r.region = RGN_PAST;
        d = (longint'(px) - bx) * (longint'(px) - bx)
          + (longint'(py) - by) * (longint'(py) - by);
        q = 128'(d) << 8;
      end else begin
        r.region = RGN_INNER;
        cr = abx * apy - aby * apx;
        if (cr < 0) cr = -cr;
        num = (128'(cr) * 128'(cr)) << 8;
        q = num / 128'(len);
      end
      r.dist_sq = (q > 128'(OUT_MAX)) ? OUT_MAX : q[OUT_W-1:0];
      return r;
    endfunction

    function void note_input(logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] bx, logic signed [15:0] by);
      pending.push_back(predict(px, py, ax, ay, bx, by));
    endfunction

    function void check_result(logic [OUT_W-1:0] dist_sq, logic [1:0] region);
      psd_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: dist=%0d region=%0d", dist_sq, region);
        return;
      end
      e = pending.pop_front();
      if (dist_sq !== e.dist_sq || region !== e.region) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected dist=%0d region=%0d, got dist=%0d region=%0d",
                   e.dist_sq, e.region, dist_sq, region);
      end
    endfunction
  endclass
endpackage

>>> sim/tb_top.sv
module tb_top;
  import psd_pkg::*;
  import tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  distance_board board = new();

  psd_in_if #(.COORD_BITS(16)) pt_if ();
  psd_out_if res_if ();

  point_segment_distance_sq_2d dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt_if.sink),
    .res_o  (res_if.source)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    pt_if.valid = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.start_x = '0;
    pt_if.start_y = '0;
    pt_if.end_x = '0;
    pt_if.end_y = '0;
    res_if.ready = 1'b0;
  end

  // receiver stall pattern
  int stall_mode;
  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready)
      board.check_result(res_if.distance_sq, res_if.nearest_region);
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= ($urandom_range(0, 3) != 0);
      2: res_if.ready <= ($urandom_range(0, 1) != 0);
      default: res_if.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(input logic [15:0] px, py, ax, ay, bx, by);
    pt_if.valid <= 1'b1;
    pt_if.point_x <= px;
    pt_if.point_y <= py;
    pt_if.start_x <= ax;
    pt_if.start_y <= ay;
    pt_if.end_x <= bx;
    pt_if.end_y <= by;
    do @(posedge clk_i); while (!pt_if.ready);
    board.note_input(px, py, ax, ay, bx, by);
  endtask

  task automatic gap(input int n);
    if (n > 0) begin
      pt_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    gap(1);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] ax, ay, bx, by, px, py;
    int burst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // degenerate, before, past, interior, endpoints, extremes
    send_beat(16'd5, 16'd5, 16'd1, 16'd1, 16'd1, 16'd1);
    send_beat(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_beat(-16'sd10, 16'd0, 16'd0, 16'd0, 16'd10, 16'd0);
    send_beat(16'd20, 16'd3, 16'd0, 16'd0, 16'd10, 16'd0);
    send_beat(16'd4, 16'd7, 16'd0, 16'd0, 16'd10, 16'd0);
    send_beat(16'd0, 16'd7, 16'd0, 16'd0, 16'd10, 16'd0);
    send_beat(16'd10, 16'd7, 16'd0, 16'd0, 16'd10, 16'd0);
    send_beat(16'd1, 16'd2, 16'd0, 16'd0, 16'd3, 16'd7);
    send_beat(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    send_beat(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_beat(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
    send_beat(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_beat(16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'hffff);
    send_beat(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h1234, 16'hedcb);
    drain();
    for (int n = 0; n < 2000; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++, n++) begin
        ax = rand_coord(); ay = rand_coord();
        bx = ($urandom_range(0, 15) == 0) ? ax : rand_coord();
        by = ($urandom_range(0, 15) == 0) ? ay : rand_coord();
        px = rand_coord(); py = rand_coord();
        send_beat(px, py, ax, ay, bx, by);
      end
      if (n > 1000 && n < 1041) drain();
      else gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12));
    end
    drain();
    repeat (100) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_top failed");
    $finish;
  end
endmodule

>>> filelist.f
sv/psd_pkg.sv
sv/psd_in_if.sv
sv/psd_out_if.sv
sv/psd_front.sv
sv/psd_div.sv
sv/point_segment_distance_sq_2d.sv
sv/psd_checker.sv
sim/tb_pkg.sv
sim/tb_top.sv
